// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the checker files
// depends on a clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off during reset
`define QAP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qap assertion failed");

// property checked during reset as well
`define QAP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("qap assertion failed");

`endif

// ----- rtl/core/qap_pkg.sv -----
// constants, types and state codes of the int8 average pooling core
// no dependencies
`default_nettype none
package qap_pkg;
	localparam int LANES = 8;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_KERNEL = 16;
	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
	localparam int DIM_W = 7;
	localparam int KER_W = 5;
	localparam int CNT_W = 9;
	localparam int ACC_W = 17;
	localparam int PROD_W = 34;
	localparam int MAG_W = 33;
	localparam int FRAC_W = 12;
	localparam int DEN_W = CNT_W + FRAC_W;
	localparam int ITER_W = $clog2(MAG_W + 1);
	localparam int IDX_W = 3;
	localparam int CFG_W = 16;
	localparam int IN_TDATA_W = 80;
	localparam int OUT_TDATA_W = 80;

	typedef enum logic [IDX_W-1:0] {
		REG_IN_HEIGHT = 3'd0,
		REG_IN_WIDTH = 3'd1,
		REG_KERNEL_HEIGHT = 3'd2,
		REG_KERNEL_WIDTH = 3'd3,
		REG_SCALE = 3'd4,
		REG_IN_ZERO = 3'd5,
		REG_OUT_ZERO = 3'd6,
		REG_COUNT_PADDING = 3'd7
	} reg_idx_t;

	typedef enum logic {
		CMD_STORE = 1'b0,
		CMD_POOL = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_RND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic mul;
		logic load;
		logic div;
		logic rnd;
	} lane_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/qap_lane.sv -----
// one channel lane: window sum, zero point and scale, rounding divide, saturation
// depends on qap_pkg
`default_nettype none
module qap_lane import qap_pkg::*; (
	input  wire logic                    clk,
	input  wire lane_ctl_t               ctl,
	input  wire logic signed [7:0]       din,
	input  wire logic signed [ACC_W-1:0] zc,
	input  wire logic [15:0]             scale,
	input  wire logic [DEN_W-1:0]        den,
	input  wire logic signed [7:0]       z2,
	output logic [7:0]                   res
);
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         mag_q;
	logic [DEN_W-1:0]         rem_q;
	logic [7:0]               res_q;

	logic signed [ACC_W:0]    diff;
	logic [DEN_W:0]           rem_sh;
	logic                     qbit;
	logic [DEN_W:0]           rem_nx;
	logic [DEN_W:0]           rem2;
	logic                     up;
	logic [MAG_W:0]           qr;
	logic signed [MAG_W+1:0]  sv;
	logic signed [MAG_W+1:0]  v;
	logic [7:0]               sat;

	always_comb begin
		diff = {acc_q[ACC_W-1], acc_q} - {zc[ACC_W-1], zc};
		rem_sh = {rem_q, mag_q[MAG_W-1]};
		qbit = rem_sh >= {1'b0, den};
		rem_nx = qbit ? rem_sh - {1'b0, den} : rem_sh;
		rem2 = {rem_q, 1'b0};
		up = (rem2 > {1'b0, den}) || ((rem2 == {1'b0, den}) && mag_q[0]);
		qr = {1'b0, mag_q} + {{MAG_W{1'b0}}, up};
		sv = neg_q ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
		v = sv + {{(MAG_W-6){z2[7]}}, z2};
		if (v > 127)
			sat = 8'h7f;
		else if (v < -128)
			sat = 8'h80;
		else
			sat = v[7:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.clr)
			acc_q <= '0;
		else if (ctl.acc)
			acc_q <= acc_q + {{(ACC_W-8){din[7]}}, din};
		if (ctl.mul)
			prod_q <= PROD_W'(diff * $signed({2'b0, scale}));
		if (ctl.load) begin
			neg_q <= prod_q[PROD_W-1];
			mag_q <= prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
			rem_q <= '0;
		end else if (ctl.div) begin
			mag_q <= {mag_q[MAG_W-2:0], qbit};
			rem_q <= rem_nx[DEN_W-1:0];
		end
		if (ctl.rnd)
			res_q <= sat;
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ----- rtl/core/qap_merge.sv -----
// merging stage: packs the lane results with the divisor into the output register
// depends on qap_pkg
`default_nettype none
module qap_merge import qap_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [LANES-1:0][7:0]  lanes,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic                   empty,
	input  wire logic                   m_tready,
	output logic                        m_tvalid,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tuser,
	output logic                        free
);
	logic                   valid_q;
	logic [63:0]            lanes_q;
	logic [CNT_W-1:0]       count_q;
	logic                   empty_q;
	logic [63:0]            packed_lanes;

	always_comb begin
		packed_lanes = '0;
		for (int l = 0; l < LANES; l++)
			packed_lanes[8*l +: 8] = empty ? 8'h00 : lanes[l];
	end

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			lanes_q <= packed_lanes;
			count_q <= empty ? '0 : count;
			empty_q <= empty;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {{(OUT_TDATA_W-64-CNT_W){1'b0}}, count_q, lanes_q};
	assign m_tuser = empty_q;
endmodule
`default_nettype wire

// ----- rtl/core/quantized_avg_pool_int8_core.sv -----
// top level of the int8 average pooling core: config registers, feature store,
// window sequencer and lane array; depends on qap_pkg, qap_lane, qap_merge
//
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   tdata {lanes_in, col, row}, tuser command
// m_        out  m_tvalid/tready   tdata {window_count, lanes_out}, tuser empty_window
// cfg_      in   cfg_we            cfg_idx, cfg_wdata
//
// a store request is written to the feature store when accepted and inside the map;
// a pool request reads the store once per clipped position, one read per cycle, then
// runs a restoring divider, one per lane
// an empty window skips the store reads and the divider
// arst_n resets control state and sets config to its defaults; the feature store is not cleared
// a waiting result holds in the output register while the next request is taken
`default_nettype none
module quantized_avg_pool_int8_core import qap_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // row, col, lanes_in
	input  wire logic                   s_tuser,  // command
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // lanes_out, window_count
	output logic                        m_tuser,  // empty_window
	input  wire logic                   cfg_we,
	input  wire logic [IDX_W-1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0]       cfg_wdata
);
	logic [DIM_W-1:0] in_height_q, in_width_q;
	logic [KER_W-1:0] kernel_height_q, kernel_width_q;
	logic [15:0]      scale_q;
	logic [7:0]       in_zero_q, out_zero_q;
	logic             count_padding_q;

	state_t state_q, state_d;

	logic [63:0] mem [DEPTH];
	logic [63:0] rd_s1;
	logic        rdv_s1;

	logic [DIM_W-1:0]  r0_q, r1_q, c0_q, c1_q, y_q, x_q;
	logic [CNT_W-1:0]  khkw_q, cnt_q, div_q;
	logic              empty_q;
	logic signed [ACC_W-1:0] zc_q;
	logic [ITER_W-1:0] iter_q;

	logic [DIM_W-1:0]  h, w;
	logic [KER_W-1:0]  kh, kw;
	logic signed [8:0] rs, cs, re, ce, r0, r1, c0, c1;
	logic              empty_win, store_ok, accept, last_col, last_pos;
	logic [CNT_W-1:0]  cnt;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	lane_ctl_t         ctl;
	logic [LANES-1:0][7:0] lane_res;
	logic              merge_load, merge_empty, merge_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q <= DIM_W'(64);
			in_width_q <= DIM_W'(64);
			kernel_height_q <= KER_W'(2);
			kernel_width_q <= KER_W'(2);
			scale_q <= 16'd4096;
			in_zero_q <= '0;
			out_zero_q <= '0;
			count_padding_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_IN_HEIGHT: in_height_q <= cfg_wdata[DIM_W-1:0];
				REG_IN_WIDTH: in_width_q <= cfg_wdata[DIM_W-1:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg_wdata[KER_W-1:0];
				REG_KERNEL_WIDTH: kernel_width_q <= cfg_wdata[KER_W-1:0];
				REG_SCALE: scale_q <= cfg_wdata;
				REG_IN_ZERO: in_zero_q <= cfg_wdata[7:0];
				REG_OUT_ZERO: out_zero_q <= cfg_wdata[7:0];
				REG_COUNT_PADDING: count_padding_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// window clipping
	always_comb begin
		h = (in_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : in_height_q;
		w = (in_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : in_width_q;
		kh = (kernel_height_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_height_q;
		kw = (kernel_width_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kernel_width_q;
		rs = {{2{s_tdata[6]}}, s_tdata[6:0]};
		cs = {{2{s_tdata[13]}}, s_tdata[13:7]};
		re = rs + $signed({4'b0, kh});
		ce = cs + $signed({4'b0, kw});
		r0 = rs[8] ? 9'sd0 : rs;
		c0 = cs[8] ? 9'sd0 : cs;
		r1 = (re > $signed({2'b0, h})) ? $signed({2'b0, h}) : re;
		c1 = (ce > $signed({2'b0, w})) ? $signed({2'b0, w}) : ce;
		empty_win = (r1 <= r0) || (c1 <= c0);
		store_ok = !rs[8] && (rs < $signed({2'b0, h})) && !cs[8]
			&& (cs < $signed({2'b0, w}));
		wr_addr = ADDR_W'(rs[DIM_W-1:0] * MAX_WIDTH + cs[DIM_W-1:0]);
		rd_addr = ADDR_W'(y_q * MAX_WIDTH + x_q);
		cnt = CNT_W'((r1_q - r0_q) * (c1_q - c0_q));
		last_col = (x_q + 1'b1) == c1_q;
		last_pos = last_col && ((y_q + 1'b1) == r1_q);
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1 <= state_q == ST_READ;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		ctl = '0;
		ctl.acc = rdv_s1;
		merge_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && cmd_t'(s_tuser) == CMD_POOL)
					state_d = empty_win ? ST_OUT : ST_SETUP;
			end
			ST_SETUP: begin
				ctl.clr = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: if (last_pos) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_MUL;
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (iter_q == ITER_W'(MAG_W - 1))
					state_d = ST_RND;
			end
			ST_RND: begin
				ctl.rnd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				merge_load = 1'b1;
				if (merge_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_t'(s_tuser) == CMD_STORE && store_ok)
			mem[wr_addr] <= s_tdata[77:14];
		if (state_q == ST_READ)
			rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r0_q <= r0[DIM_W-1:0];
			r1_q <= r1[DIM_W-1:0];
			c0_q <= c0[DIM_W-1:0];
			c1_q <= c1[DIM_W-1:0];
			empty_q <= empty_win;
			khkw_q <= CNT_W'(kh * kw);
		end
		if (state_q == ST_SETUP) begin
			cnt_q <= cnt;
			div_q <= count_padding_q ? khkw_q : cnt;
			y_q <= r0_q;
			x_q <= c0_q;
		end
		if (state_q == ST_READ) begin
			zc_q <= ACC_W'($signed(in_zero_q) * $signed({1'b0, cnt_q}));
			x_q <= last_col ? c0_q : x_q + 1'b1;
			if (last_col)
				y_q <= y_q + 1'b1;
		end
		if (state_q == ST_LOAD)
			iter_q <= '0;
		else if (state_q == ST_DIV)
			iter_q <= iter_q + 1'b1;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		qap_lane u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.din   ($signed(rd_s1[8*l +: 8])),
			.zc    (zc_q),
			.scale (scale_q),
			.den   ({div_q, {FRAC_W{1'b0}}}),
			.z2    ($signed(out_zero_q)),
			.res   (lane_res[l])
		);
	end

	assign merge_empty = empty_q;

	qap_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (merge_load),
		.lanes    (lane_res),
		.count    (div_q),
		.empty    (merge_empty),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.free     (merge_free)
	);
endmodule
`default_nettype wire

// ----- rtl/core/qap_checker.sv -----
// port-level checker for the int8 average pooling core, bound to the top level
// depends on qap_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module qap_checker import qap_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   s_tuser,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tuser
);
	`QAP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
	`QAP_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata))
	`QAP_ASSERT(a_empty_zero, m_tvalid && m_tuser |-> m_tdata == '0)
	`QAP_ASSERT(a_pool_busy, s_tvalid && s_tready && s_tuser |=> !s_tready)
	`QAP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid)
endmodule

bind quantized_avg_pool_int8_core qap_checker u_qap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
